@@ design/pbf_pkg.sv @@
// Shared types and constants for the PWM backlight fader.
// No dependencies; used by pbf_step and pwm_backlight_fader_core.
package pbf_pkg;

   // Fixed field widths
   localparam int FRAC_BITS     = 16;  // fractional bits of the brightness value
   localparam int STEP_W        = 27;  // fade step register width
   localparam int PERIOD_W      = 16;  // timer period width
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 27;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 24;

   // Default PWM resolution (levels = 2**LEVEL_BITS)
   localparam int LEVEL_BITS_DEF = 8;

   // First expiry after a fade starts the timer
   localparam logic [PERIOD_W-1:0] START_DELAY = 16'd2;

   // Register reset values
   localparam logic [STEP_W-1:0]   FADE_IN_RST  = 27'd279620;
   localparam logic [STEP_W-1:0]   FADE_OUT_RST = 27'd41943;
   localparam logic [PERIOD_W-1:0] BASE_RST     = 16'd5000;

   // Input item kind, carried on req_tuser
   typedef enum logic {
      FUNC_EXPIRE = 1'b0,
      FUNC_FADE   = 1'b1
   } func_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FADE_IN  = 2'd0,
      CSR_FADE_OUT = 2'd1,
      CSR_BASE     = 2'd2
   } csr_idx_type;

   // Single-bit control state
   typedef struct packed {
      logic target_full;
      logic phase_main;
      logic timer_active;
      logic light_state;
   } flags_type;

   // Result beat
   typedef struct packed {
      logic                sleep_request;
      logic                fade_done;
      logic                timer_run;
      logic [PERIOD_W-1:0] period_out;
      logic                light_on;
   } rsp_type;

endpackage

@@ design/pwm_backlight_fader_core.sv @@
// Top level of the PWM backlight fader: stream ports, registers and state.
// Depends on pbf_pkg and pbf_step.

// Takes one beat per clock while no result is held back, and returns exactly
// one result beat for each: a beat sits in the input register, then the fader
// state and result register update together when the result register is free,
// and a held result blocks the next beat. Each beat's work is one 16 x 9-bit
// multiply (base period times level) plus a saturating add or subtract of the
// fade step. req_tuser is the kind (0 = timer expiry, 1 = fade request) and
// req_tdata[0] is fade_up. Registers on csr_* (0 fade-in step, 1 fade-out
// step, 2 base period) take effect at once and must be written only while
// no beats are in flight.
module pwm_backlight_fader_core #(
   parameter int LEVEL_BITS = pbf_pkg::LEVEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pbf_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [0] fade_up, rest zero
   input  logic                               req_tuser,   // [0] func
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] light_on, [16:1] period_out, [17] timer_run, [18] fade_done,
   // [19] sleep_request, rest zero
   output logic [pbf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                               csr_we,
   input  logic [pbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FRAC_W = LEVEL_BITS + pbf_pkg::FRAC_BITS + 1;
   localparam int LVL_W  = LEVEL_BITS + 1;
   localparam int RSP_W  = $bits(pbf_pkg::rsp_type);

   // configuration registers
   logic [pbf_pkg::STEP_W-1:0]   fade_in_ff,  fade_in_in;
   logic [pbf_pkg::STEP_W-1:0]   fade_out_ff, fade_out_in;
   logic [pbf_pkg::PERIOD_W-1:0] base_ff,     base_in;

   // input register
   logic                 in_valid_ff, in_valid_in;
   pbf_pkg::func_type    in_func_ff,  in_func_in;
   logic                 in_up_ff,    in_up_in;

   // fader state
   logic [FRAC_W-1:0]    frac_ff,    frac_in;
   logic [LVL_W-1:0]     latched_ff, latched_in;
   pbf_pkg::flags_type   flags_ff,   flags_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pbf_pkg::rsp_type     rsp_ff,       rsp_in;

   logic [FRAC_W-1:0]    frac_step;
   logic [LVL_W-1:0]     latched_step;
   pbf_pkg::flags_type   flags_step;
   pbf_pkg::rsp_type     rsp_step;
   logic                 out_free;
   logic                 advance;
   logic                 req_fire;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pbf_pkg::RSP_TDATA_W'(rsp_ff);

   pbf_step #(
      .LEVEL_BITS(LEVEL_BITS)
   ) u_step (
      .func          (in_func_ff),
      .fade_up       (in_up_ff),
      .fade_in_step  (fade_in_ff),
      .fade_out_step (fade_out_ff),
      .base_period   (base_ff),
      .frac_cur      (frac_ff),
      .latched_cur   (latched_ff),
      .flags_cur     (flags_ff),
      .frac_nxt      (frac_step),
      .latched_nxt   (latched_step),
      .flags_nxt     (flags_step),
      .rsp           (rsp_step)
   );

   // register writes
   always_comb begin
      fade_in_in  = fade_in_ff;
      fade_out_in = fade_out_ff;
      base_in     = base_ff;
      if (csr_we) begin
         case (csr_index)
            pbf_pkg::CSR_FADE_IN:  fade_in_in  = csr_wdata[pbf_pkg::STEP_W-1:0];
            pbf_pkg::CSR_FADE_OUT: fade_out_in = csr_wdata[pbf_pkg::STEP_W-1:0];
            pbf_pkg::CSR_BASE:     base_in     = csr_wdata[pbf_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // input register, state and result register next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_func_in   = in_func_ff;
      in_up_in     = in_up_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_func_in  = pbf_pkg::func_type'(req_tuser);
         in_up_in    = req_tdata[0];
      end

      frac_in      = frac_ff;
      latched_in   = latched_ff;
      flags_in     = flags_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         frac_in      = frac_step;
         latched_in   = latched_step;
         flags_in     = flags_step;
         rsp_in       = rsp_step;
         rsp_valid_in = 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_in_ff   <= pbf_pkg::FADE_IN_RST;
         fade_out_ff  <= pbf_pkg::FADE_OUT_RST;
         base_ff      <= pbf_pkg::BASE_RST;
         in_valid_ff  <= 1'b0;
         frac_ff      <= '0;
         latched_ff   <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fade_in_ff   <= fade_in_in;
         fade_out_ff  <= fade_out_in;
         base_ff      <= base_in;
         in_valid_ff  <= in_valid_in;
         frac_ff      <= frac_in;
         latched_ff   <= latched_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_func_ff <= in_func_in;
      in_up_ff   <= in_up_in;
      rsp_ff     <= rsp_in;
   end

   // result width check at elaboration
   if (RSP_W > pbf_pkg::RSP_TDATA_W) begin : g_width_bad
      $error("result does not fit rsp_tdata");
   end

endmodule

@@ design/pbf_step.sv @@
// Next-state and result logic for one fader item (expiry or fade request).
// Depends on pbf_pkg. Purely combinational: one 16 x (LEVEL_BITS+1) multiply.
module pbf_step #(
   parameter int LEVEL_BITS = pbf_pkg::LEVEL_BITS_DEF
) (
   input  pbf_pkg::func_type                   func,
   input  logic                                fade_up,
   input  logic [pbf_pkg::STEP_W-1:0]          fade_in_step,
   input  logic [pbf_pkg::STEP_W-1:0]          fade_out_step,
   input  logic [pbf_pkg::PERIOD_W-1:0]        base_period,
   input  logic [LEVEL_BITS+pbf_pkg::FRAC_BITS:0] frac_cur,
   input  logic [LEVEL_BITS:0]                 latched_cur,
   input  pbf_pkg::flags_type                  flags_cur,
   output logic [LEVEL_BITS+pbf_pkg::FRAC_BITS:0] frac_nxt,
   output logic [LEVEL_BITS:0]                 latched_nxt,
   output pbf_pkg::flags_type                  flags_nxt,
   output pbf_pkg::rsp_type                    rsp
);

   localparam int FRAC_W = LEVEL_BITS + pbf_pkg::FRAC_BITS + 1;
   localparam int LVL_W  = LEVEL_BITS + 1;
   localparam int SUM_W  = ((FRAC_W > pbf_pkg::STEP_W) ? FRAC_W : pbf_pkg::STEP_W) + 1;
   localparam int PROD_W = pbf_pkg::PERIOD_W + LVL_W;

   localparam logic [LVL_W-1:0]  LEVEL_COUNT = LVL_W'(1) << LEVEL_BITS;
   localparam logic [FRAC_W-1:0] FRAC_MAX    = FRAC_W'(1) << (FRAC_W - 1);

   logic [LVL_W-1:0]           cur_level;
   logic [LVL_W-1:0]           tgt_level;
   logic [LVL_W-1:0]           rest_level;
   logic [LVL_W-1:0]           mul_op;
   logic [PROD_W-1:0]          product;
   logic [pbf_pkg::PERIOD_W-1:0] scaled;
   logic [SUM_W-1:0]           frac_ext;
   logic [SUM_W-1:0]           in_ext;
   logic [SUM_W-1:0]           out_ext;
   logic [SUM_W-1:0]           sum_up;
   logic [FRAC_W-1:0]          frac_up;
   logic [FRAC_W-1:0]          frac_down;
   logic [pbf_pkg::STEP_W-1:0] sel_step;
   logic                       idle;

   // Level of the fraction, target and remaining off share of the cycle
   assign cur_level  = frac_cur[FRAC_W-1:pbf_pkg::FRAC_BITS];
   assign tgt_level  = flags_cur.target_full ? LEVEL_COUNT : '0;
   assign rest_level = LEVEL_COUNT - {1'b0, latched_cur[LEVEL_BITS-1:0]};

   // Shared period scaler: on time in start phase, off time in main phase
   assign mul_op  = flags_cur.phase_main ? rest_level : cur_level;
   assign product = PROD_W'(base_period) * PROD_W'(mul_op);
   assign scaled  = product[LEVEL_BITS +: pbf_pkg::PERIOD_W];

   // Saturating ramps toward full and toward off
   assign frac_ext  = SUM_W'(frac_cur);
   assign in_ext    = SUM_W'(fade_in_step);
   assign out_ext   = SUM_W'(fade_out_step);
   assign sum_up    = frac_ext + in_ext;
   assign frac_up   = (sum_up > SUM_W'(FRAC_MAX)) ? FRAC_MAX : sum_up[FRAC_W-1:0];
   assign frac_down = (frac_ext > out_ext) ? FRAC_W'(frac_ext - out_ext) : '0;

   assign sel_step = fade_up ? fade_in_step : fade_out_step;

   always_comb begin
      frac_nxt           = frac_cur;
      latched_nxt        = latched_cur;
      flags_nxt          = flags_cur;
      rsp                = '0;
      idle               = 1'b0;

      if (func == pbf_pkg::FUNC_EXPIRE) begin
         if (flags_cur.timer_active) begin
            rsp.period_out = base_period;
            if (!flags_cur.phase_main) begin
               // start phase: latch level, light on for the on share
               latched_nxt = cur_level;
               if (cur_level != '0 && cur_level < LEVEL_COUNT) begin
                  flags_nxt.light_state = 1'b1;
                  rsp.period_out        = scaled;
                  flags_nxt.phase_main  = 1'b1;
               end else begin
                  flags_nxt.light_state = (cur_level != '0);
                  idle                  = (cur_level == tgt_level);
               end
               if (cur_level < tgt_level) begin
                  frac_nxt = frac_up;
               end else if (cur_level > tgt_level) begin
                  frac_nxt = frac_down;
               end
            end else begin
               // main phase: off for the rest of the cycle
               flags_nxt.light_state = 1'b0;
               rsp.period_out        = scaled;
               flags_nxt.phase_main  = 1'b0;
            end
            if (idle) begin
               flags_nxt.timer_active = 1'b0;
               rsp.fade_done          = 1'b1;
               rsp.period_out         = '0;
               rsp.sleep_request      = (cur_level == '0);
            end
         end
      end else begin
         if (sel_step != '0) begin
            if (flags_cur.target_full != fade_up) begin
               flags_nxt.target_full = fade_up;
               if (!flags_cur.timer_active) begin
                  flags_nxt.timer_active = 1'b1;
                  rsp.period_out         = pbf_pkg::START_DELAY;
               end
            end
         end else begin
            // zero step: switch at once
            flags_nxt.target_full = fade_up;
            frac_nxt              = fade_up ? FRAC_MAX : '0;
            flags_nxt.light_state = fade_up;
            rsp.sleep_request     = !fade_up;
         end
      end

      rsp.light_on  = flags_nxt.light_state;
      rsp.timer_run = flags_nxt.timer_active;
   end

endmodule
